// ===== sv/lane_row_segment_picker_defines.svh =====
// Assertion macros shared by the lane row segment picker RTL.
`ifndef LANE_ROW_SEGMENT_PICKER_DEFINES_SVH
`define LANE_ROW_SEGMENT_PICKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LRSP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lrsp check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LRSP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lrsp check failed");

`endif

// ===== sv/lrsp_pkg.sv =====
// Constants and types of the lane row segment picker.
`default_nettype none

package lrsp_pkg;

  localparam int LANE_COLS  = 512;
  localparam int FRAME_COLS = 640;
  localparam int MIN_WIDTH  = 100;
  localparam int MAX_WIDTH  = 600;

  localparam int PIX_W   = 16;
  localparam int COL_W   = 10;  // column counter, holds LANE_COLS
  localparam int POS_W   = 9;   // lane-map column index
  localparam int SUM_W   = 10;  // first + last column
  localparam int MID_W   = 13;
  localparam int SCALE_W = 16;
  localparam int X_W     = 10;
  localparam int PROD_W  = SUM_W + SCALE_W + 1;
  localparam int POSX_W  = PROD_W - 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIT_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_START    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCAN_END      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_GAP       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SEG_HITS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MID_LANE_Q4   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COL_SCALE_Q8  = 3'd6;

  // window and segment settings after clamping
  typedef struct packed {
    logic signed [PIX_W-1:0] thr;
    logic [POS_W-1:0]        start;
    logic [COL_W-1:0]        stop;
    logic [POS_W-1:0]        gap;
    logic [COL_W-1:0]        min_hits;
    logic [MID_W-1:0]        mid;
  } seg_cfg_t;

  // lane candidates of one row
  typedef struct packed {
    logic             left_valid;
    logic [SUM_W-1:0] left_sum;
    logic             right_valid;
    logic [SUM_W-1:0] right_sum;
  } row_sum_t;

endpackage

`default_nettype wire

// ===== sv/lrsp_ifs.sv =====
// Valid/ready channel interfaces for pixel items and row results.
`default_nettype none

interface lrsp_in_if import lrsp_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [PIX_W-1:0] pixel_value;
  logic                    row_last;

  modport source (output valid, output pixel_value, output row_last, input ready);
  modport sink   (input valid, input pixel_value, input row_last, output ready);
endinterface

interface lrsp_out_if import lrsp_pkg::*; ();
  logic           valid;
  logic           ready;
  logic           found;
  logic [X_W-1:0] left_x;
  logic [X_W-1:0] right_x;

  modport source (output valid, output found, output left_x, output right_x, input ready);
  modport sink   (input valid, input found, input left_x, input right_x, output ready);
endinterface

`default_nettype wire

// ===== sv/lrsp_seg.sv =====
// Segment tracker: hit test, segment grouping and left/right candidate pick.
`default_nettype none

module lrsp_seg import lrsp_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire seg_cfg_t                cfg,
  input  wire logic                    take,
  input  wire logic signed [PIX_W-1:0] pixel_value,
  input  wire logic                    row_last,
  output row_sum_t                     row_sum
);

  logic [COL_W-1:0] column_r,   column_nxt;
  logic             seg_open_r, seg_open_nxt;
  logic [POS_W-1:0] first_r,    first_nxt;
  logic [POS_W-1:0] prev_r,     prev_nxt;
  logic [COL_W-1:0] hits_r,     hits_nxt;
  row_sum_t         cand_r,     cand_nxt;

  logic [POS_W-1:0] col;
  logic             hit;
  logic             gap_break;
  logic             open_mid;
  row_sum_t         cand_mid;
  row_sum_t         cand_end;

  function automatic row_sum_t close_seg(input row_sum_t cur, input logic is_open,
                                         input logic [COL_W-1:0] hits,
                                         input logic [POS_W-1:0] first,
                                         input logic [POS_W-1:0] final_col,
                                         input seg_cfg_t c);
    row_sum_t         res;
    logic [SUM_W-1:0] sum;
    res = cur;
    sum = SUM_W'(first) + SUM_W'(final_col);
    if (is_open && hits >= c.min_hits) begin
      if ({sum, 3'b000} < c.mid) begin
        res.left_valid = 1'b1;
        res.left_sum   = sum;
      end else if (!cur.right_valid) begin
        res.right_valid = 1'b1;
        res.right_sum   = sum;
      end
    end
    return res;
  endfunction

  assign col = column_r[POS_W-1:0];

  always_comb begin
    hit = (column_r < COL_W'(LANE_COLS)) && (column_r >= COL_W'(cfg.start)) &&
          (column_r < cfg.stop) && (pixel_value >= cfg.thr);
    gap_break = seg_open_r && ((col - prev_r) > cfg.gap);

    cand_mid = (hit && gap_break) ?
               close_seg(cand_r, 1'b1, hits_r, first_r, prev_r, cfg) : cand_r;
    open_mid = seg_open_r && !(hit && gap_break);

    seg_open_nxt = open_mid;
    first_nxt    = first_r;
    prev_nxt     = prev_r;
    hits_nxt     = hits_r;
    if (hit) begin
      if (open_mid) begin
        prev_nxt = col;
        if (hits_r < COL_W'(LANE_COLS)) hits_nxt = hits_r + COL_W'(1);
      end else begin
        seg_open_nxt = 1'b1;
        first_nxt    = col;
        prev_nxt     = col;
        hits_nxt     = COL_W'(1);
      end
    end

    // the open segment is closed at the end of the row
    cand_end = close_seg(cand_mid, seg_open_nxt, hits_nxt, first_nxt, prev_nxt, cfg);
    cand_nxt = cand_mid;

    column_nxt = (column_r < COL_W'(LANE_COLS)) ? column_r + COL_W'(1) : column_r;

    if (row_last) begin
      column_nxt   = '0;
      seg_open_nxt = 1'b0;
      first_nxt    = '0;
      prev_nxt     = '0;
      hits_nxt     = '0;
      cand_nxt     = '0;
    end
  end

  assign row_sum = cand_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_r   <= '0;
      seg_open_r <= 1'b0;
      first_r    <= '0;
      prev_r     <= '0;
      hits_r     <= '0;
      cand_r     <= '0;
    end else if (take) begin
      column_r   <= column_nxt;
      seg_open_r <= seg_open_nxt;
      first_r    <= first_nxt;
      prev_r     <= prev_nxt;
      hits_r     <= hits_nxt;
      cand_r     <= cand_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/lane_row_segment_picker.sv =====
// Top level of the lane row segment picker: config, segment tracker, result pipeline.
//
//   port     dir   handshake       carries
//   in_if    in    valid/ready     pixel_value, row_last
//   out_if   out   valid/ready     found, left_x, right_x (one item per row)
//   cfg_*    in    cfg_we only     cfg_idx, cfg_wdata
//
// One pixel item is taken per cycle while in_if.ready is high; segment state updates
// at acceptance. A row_last item enters a three-register result path (row sums, scaled
// positions, output); its row sums are registered at acceptance and move on to
// the scaled positions and then the output register. Each stage advances into an
// empty slot, so a stalled output only blocks input once all three result slots are full.
// Reset is synchronous; no clearing pass.
`default_nettype none
`include "lane_row_segment_picker_defines.svh"

module lane_row_segment_picker import lrsp_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  lrsp_in_if.sink                    in_if,
  lrsp_out_if.source                 out_if,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  logic signed [PIX_W-1:0] hit_threshold_r;
  logic [POS_W-1:0]        scan_start_r;
  logic [COL_W-1:0]        scan_end_r;
  logic [POS_W-1:0]        seg_gap_r;
  logic [COL_W-1:0]        min_seg_hits_r;
  logic [MID_W-1:0]        mid_lane_q4_r;
  logic [SCALE_W-1:0]      col_scale_q8_r;

  seg_cfg_t         seg_cfg;
  logic [POS_W-1:0] start_c;
  logic [COL_W-1:0] stop_c;
  row_sum_t         row_sum;
  logic             take;

  // result path
  logic              s1_v_r;
  row_sum_t          s1_sum_r;
  logic              s2_v_r;
  logic              s2_ok_r;
  logic [POSX_W-1:0] s2_l_r;
  logic [POSX_W-1:0] s2_r_r;
  logic              out_v_r;
  logic              found_r;
  logic [X_W-1:0]    left_x_r;
  logic [X_W-1:0]    right_x_r;

  logic              out_load;
  logic              s2_load;
  logic              s1_free;
  logic [PROD_W-1:0] prod_l;
  logic [PROD_W-1:0] prod_r;
  logic [X_W-1:0]    l_sat;
  logic [X_W-1:0]    r_sat;
  logic [X_W-1:0]    width;
  logic              found_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_threshold_r <= '0;
      scan_start_r    <= '0;
      scan_end_r      <= COL_W'(512);
      seg_gap_r       <= POS_W'(1);
      min_seg_hits_r  <= COL_W'(1);
      mid_lane_q4_r   <= MID_W'(4096);
      col_scale_q8_r  <= SCALE_W'(320);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_HIT_THRESHOLD: hit_threshold_r <= cfg_wdata;
        REG_SCAN_START:    scan_start_r    <= cfg_wdata[POS_W-1:0];
        REG_SCAN_END:      scan_end_r      <= cfg_wdata[COL_W-1:0];
        REG_SEG_GAP:       seg_gap_r       <= cfg_wdata[POS_W-1:0];
        REG_MIN_SEG_HITS:  min_seg_hits_r  <= cfg_wdata[COL_W-1:0];
        REG_MID_LANE_Q4:   mid_lane_q4_r   <= cfg_wdata[MID_W-1:0];
        REG_COL_SCALE_Q8:  col_scale_q8_r  <= cfg_wdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // window always holds at least one column
  always_comb begin
    start_c = (COL_W'(scan_start_r) > COL_W'(LANE_COLS - 1)) ?
              POS_W'(LANE_COLS - 1) : scan_start_r;
    stop_c  = (scan_end_r > COL_W'(LANE_COLS)) ? COL_W'(LANE_COLS) : scan_end_r;
    if (stop_c < COL_W'(start_c) + COL_W'(1)) stop_c = COL_W'(start_c) + COL_W'(1);
    seg_cfg.thr      = hit_threshold_r;
    seg_cfg.start    = start_c;
    seg_cfg.stop     = stop_c;
    seg_cfg.gap      = (seg_gap_r == '0) ? POS_W'(1) : seg_gap_r;
    seg_cfg.min_hits = min_seg_hits_r;
    seg_cfg.mid      = mid_lane_q4_r;
  end

  assign out_load = s2_v_r && (!out_v_r || out_if.ready);
  assign s2_load  = s1_v_r && (!s2_v_r || out_load);
  assign s1_free  = !s1_v_r || s2_load;
  assign take     = in_if.valid && s1_free;

  assign in_if.ready = s1_free;

  lrsp_seg u_seg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (seg_cfg),
    .take        (take),
    .pixel_value (in_if.pixel_value),
    .row_last    (in_if.row_last),
    .row_sum     (row_sum)
  );

  // scale to frame pixels, round half up
  assign prod_l = PROD_W'(s1_sum_r.left_sum) * PROD_W'(col_scale_q8_r) + PROD_W'(256);
  assign prod_r = PROD_W'(s1_sum_r.right_sum) * PROD_W'(col_scale_q8_r) + PROD_W'(256);

  always_comb begin
    l_sat = (s2_l_r > POSX_W'(FRAME_COLS - 1)) ? X_W'(FRAME_COLS - 1) : s2_l_r[X_W-1:0];
    r_sat = (s2_r_r > POSX_W'(FRAME_COLS - 1)) ? X_W'(FRAME_COLS - 1) : s2_r_r[X_W-1:0];
    width = r_sat - l_sat;
    found_nxt = s2_ok_r && (r_sat >= l_sat) &&
                (width >= X_W'(MIN_WIDTH)) && (width <= X_W'(MAX_WIDTH));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_free) s1_v_r <= take && in_if.row_last;
      if (!s2_v_r || out_load) s2_v_r <= s2_load;
      if (!out_v_r || out_if.ready) out_v_r <= out_load;
    end
  end

  always_ff @(posedge clk) begin
    if (take && in_if.row_last && s1_free) s1_sum_r <= row_sum;
    if (s2_load) begin
      s2_ok_r <= s1_sum_r.left_valid && s1_sum_r.right_valid &&
                 (s1_sum_r.right_sum > s1_sum_r.left_sum);
      s2_l_r  <= prod_l[PROD_W-1:9];
      s2_r_r  <= prod_r[PROD_W-1:9];
    end
    if (out_load) begin
      found_r   <= found_nxt;
      left_x_r  <= found_nxt ? l_sat : '0;
      right_x_r <= found_nxt ? r_sat : '0;
    end
  end

  assign out_if.valid   = out_v_r;
  assign out_if.found   = found_r;
  assign out_if.left_x  = left_x_r;
  assign out_if.right_x = right_x_r;

  `LRSP_ASSERT_NOW(a_not_found_zero, out_v_r && !found_r, (left_x_r == '0) && (right_x_r == '0))
  `LRSP_ASSERT_NOW(a_found_width, out_v_r && found_r, right_x_r >= left_x_r + X_W'(MIN_WIDTH))
  `LRSP_ASSERT_NEXT(a_s1_holds, s1_v_r && !s2_load, s1_v_r)
  `LRSP_ASSERT_NOW(a_block_only_full, !s1_free, s1_v_r && s2_v_r && out_v_r)

endmodule

`default_nettype wire

// ===== tb/tb_lane_row_segment_picker.sv =====
// Self-checking testbench for the lane row segment picker.
`timescale 1ns / 100ps

module tb_lane_row_segment_picker import lrsp_pkg::*; ();

  localparam int LONG_HOLD   = 300;   // receiver hold-off, in cycles
  localparam int STUCK_LIMIT = 2000;  // cycles with no handshake before giving up

  typedef struct packed {
    logic signed [PIX_W-1:0] pix;
    logic                    is_last;
  } pixel_item_t;

  typedef struct packed {
    logic           found;
    logic [X_W-1:0] left_x;
    logic [X_W-1:0] right_x;
  } row_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  lrsp_in_if  pixel_if ();
  lrsp_out_if result_if ();

  lane_row_segment_picker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (pixel_if),
    .out_if    (result_if),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // register copies
  logic signed [PIX_W-1:0] thr_q;
  logic [POS_W-1:0]        start_q;
  logic [COL_W-1:0]        end_q;
  logic [POS_W-1:0]        gap_q;
  logic [COL_W-1:0]        min_hits_q;
  logic [MID_W-1:0]        mid_q;
  logic [SCALE_W-1:0]      scale_q;

  // row tracking state
  logic [COL_W-1:0] col_cnt;
  logic             seg_open_m;
  logic [POS_W-1:0] seg_first_m;
  logic [POS_W-1:0] seg_prev_m;
  logic [COL_W-1:0] seg_hits_m;
  logic             left_ok;
  logic [SUM_W-1:0] left_sum;
  logic             right_ok;
  logic [SUM_W-1:0] right_sum;

  pixel_item_t pixel_queue[$];
  row_result_t expected_rows[$];

  int  pushed_items   = 0;
  int  accepted_items = 0;
  int  rand_items     = 0;
  int  rand_rows      = 0;
  int  phase_items    = 0;
  int  rows_checked   = 0;
  int  rows_found     = 0;
  int  mismatches     = 0;
  int  idle_mode      = 0;  // 0 none, 1 sender, 2 receiver, 3 both
  int  hold_requests  = 0;
  int  holds_done     = 0;
  int  hold_left      = 0;
  int  stuck_cycles   = 0;
  int  phase_cnt      = 0;
  logic in_taken      = 1'b0;

  task automatic clear_row_state();
    col_cnt     = '0;
    seg_open_m  = 1'b0;
    seg_first_m = '0;
    seg_prev_m  = '0;
    seg_hits_m  = '0;
    left_ok     = 1'b0;
    left_sum    = '0;
    right_ok    = 1'b0;
    right_sum   = '0;
  endtask

  task automatic close_open_segment();
    int sum;
    if (seg_open_m) begin
      seg_open_m = 1'b0;
      if (seg_hits_m >= min_hits_q) begin
        sum = int'(seg_first_m) + int'(seg_prev_m);
        if (sum * 8 < int'(mid_q)) begin
          left_ok  = 1'b1;
          left_sum = sum[SUM_W-1:0];
        end else if (!right_ok) begin
          right_ok  = 1'b1;
          right_sum = sum[SUM_W-1:0];
        end
      end
    end
  endtask

  function automatic logic [X_W-1:0] frame_pos(input logic [SUM_W-1:0] sum);
    longint v;
    v = (longint'(sum) * longint'(scale_q) + 256) >>> 9;
    if (v > FRAME_COLS - 1) v = FRAME_COLS - 1;
    return v[X_W-1:0];
  endfunction

  // Advances the row state by one pixel; queues the row result on the last one.
  task automatic track_pixel(input logic signed [PIX_W-1:0] pix, input logic is_last);
    int          col;
    int          lo;
    int          hi;
    int          gap;
    int          w;
    logic        hit;
    logic [X_W-1:0] lx;
    logic [X_W-1:0] rx;
    row_result_t res;
    col = col_cnt;
    lo  = start_q;
    if (lo > LANE_COLS - 1) lo = LANE_COLS - 1;
    hi = end_q;
    if (hi > LANE_COLS) hi = LANE_COLS;
    if (hi < lo + 1) hi = lo + 1;
    gap = (gap_q == 0) ? 1 : int'(gap_q);
    hit = (col < LANE_COLS) && (col >= lo) && (col < hi) && (pix >= thr_q);
    if (hit) begin
      if (seg_open_m && (col - int'(seg_prev_m) > gap)) close_open_segment();
      if (seg_open_m) begin
        seg_prev_m = col[POS_W-1:0];
        if (seg_hits_m < LANE_COLS) seg_hits_m = seg_hits_m + 1'b1;
      end else begin
        seg_open_m  = 1'b1;
        seg_first_m = col[POS_W-1:0];
        seg_prev_m  = col[POS_W-1:0];
        seg_hits_m  = COL_W'(1);
      end
    end
    if (col_cnt < LANE_COLS) col_cnt = col_cnt + 1'b1;
    if (is_last) begin
      close_open_segment();
      res = '0;
      if (left_ok && right_ok && right_sum > left_sum) begin
        lx = frame_pos(left_sum);
        rx = frame_pos(right_sum);
        w  = int'(rx) - int'(lx);
        if (w >= MIN_WIDTH && w <= MAX_WIDTH) begin
          res.found   = 1'b1;
          res.left_x  = lx;
          res.right_x = rx;
        end
      end
      expected_rows = {expected_rows, res};
      clear_row_state();
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value[CFG_DATA_W-1:0];
    case (idx)
      REG_HIT_THRESHOLD: thr_q      = value[PIX_W-1:0];
      REG_SCAN_START:    start_q    = value[POS_W-1:0];
      REG_SCAN_END:      end_q      = value[COL_W-1:0];
      REG_SEG_GAP:       gap_q      = value[POS_W-1:0];
      REG_MIN_SEG_HITS:  min_hits_q = value[COL_W-1:0];
      REG_MID_LANE_Q4:   mid_q      = value[MID_W-1:0];
      REG_COL_SCALE_Q8:  scale_q    = value[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic configure(input int thr, input int start, input int stop, input int gap,
                           input int minh, input int mid, input int scale);
    write_reg(REG_HIT_THRESHOLD, thr);
    write_reg(REG_SCAN_START, start);
    write_reg(REG_SCAN_END, stop);
    write_reg(REG_SEG_GAP, gap);
    write_reg(REG_MIN_SEG_HITS, minh);
    write_reg(REG_MID_LANE_Q4, mid);
    write_reg(REG_COL_SCALE_Q8, scale);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_item(input int pix, input logic is_last);
    pixel_item_t it;
    it.pix     = pix[PIX_W-1:0];
    it.is_last = is_last;
    pixel_queue = {pixel_queue, it};
    pushed_items++;
  endtask

  // Score on the chosen side of the current threshold, often right at the boundary.
  function automatic logic signed [PIX_W-1:0] score_value(input logic want_hit);
    int   lo;
    int   hi;
    logic up;
    up = want_hit || (thr_q == -32768);
    if (up) begin
      lo = thr_q;
      hi = 32767;
    end else begin
      lo = -32768;
      hi = int'(thr_q) - 1;
    end
    if ($urandom_range(0, 7) == 0) return PIX_W'(up ? lo : hi);
    return PIX_W'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  // Lane-like rows carry one band left and one right of the middle, with holes
  // and stray hits; noise rows are coin flips.
  task automatic queue_row(input int len, input logic lane_like, input int hit_pct);
    int   mid;
    int   l0;
    int   lw;
    int   r0;
    int   rw;
    int   c;
    logic want;
    mid = len / 2;
    l0  = $urandom_range(0, (mid > 2) ? mid - 2 : 0);
    lw  = $urandom_range(1, 3);
    r0  = $urandom_range(mid, (len > mid) ? len - 1 : mid);
    rw  = $urandom_range(1, 3);
    for (c = 0; c < len; c++) begin
      if (lane_like)
        want = (((c >= l0) && (c < l0 + lw)) || ((c >= r0) && (c < r0 + rw)))
               ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 11) == 0);
      else
        want = ($urandom_range(0, 99) < hit_pct);
      push_item(score_value(want), c == len - 1);
    end
    rand_items  += len;
    phase_items += len;
    rand_rows++;
  endtask

  // Config may only change once the block has gone quiet.
  task automatic drain();
    while (accepted_items != pushed_items || expected_rows.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // pixel driver
  always @(negedge clk) begin : drive_pixels
    pixel_item_t nxt;
    if (rst_n && (!pixel_if.valid || in_taken)) begin
      if (pixel_queue.size() != 0 &&
          !((idle_mode == 1 && $urandom_range(0, 99) < 72) ||
            (idle_mode == 3 && $urandom_range(0, 99) < 29))) begin
        nxt = pixel_queue.pop_front();
        pixel_if.valid       <= 1'b1;
        pixel_if.pixel_value <= nxt.pix;
        pixel_if.row_last    <= nxt.is_last;
      end else begin
        pixel_if.valid <= 1'b0;
      end
    end
  end

  // result receiver, with an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      result_if.ready <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done      <= holds_done + 1;
      hold_left       <= LONG_HOLD;
      result_if.ready <= 1'b0;
    end else begin
      result_if.ready <= !((idle_mode == 2 && $urandom_range(0, 99) < 72) ||
                           (idle_mode == 3 && $urandom_range(0, 99) < 29));
    end
  end

  // handshake monitor and checker
  always @(posedge clk) begin : watch_channels
    row_result_t got;
    row_result_t want;
    in_taken <= pixel_if.valid && pixel_if.ready;
    if (rst_n && pixel_if.valid && pixel_if.ready) begin
      track_pixel(pixel_if.pixel_value, pixel_if.row_last);
      accepted_items++;
    end
    if (rst_n && result_if.valid && result_if.ready) begin
      got.found   = result_if.found;
      got.left_x  = result_if.left_x;
      got.right_x = result_if.right_x;
      rows_checked++;
      if (got.found === 1'b1) rows_found++;
      if (expected_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected row result: found=%0d left_x=%0d right_x=%0d",
                   got.found, got.left_x, got.right_x);
      end else begin
        want = expected_rows.pop_front();
        if (got.found !== want.found || got.left_x !== want.left_x ||
            got.right_x !== want.right_x) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row %0d: exp found=%0d l=%0d r=%0d, got found=%0d l=%0d r=%0d",
                     rows_checked, want.found, want.left_x, want.right_x,
                     got.found, got.left_x, got.right_x);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (pixel_if.valid && pixel_if.ready) || (result_if.valid && result_if.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == STUCK_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STUCK_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    int lp;
    int thr;
    int start;
    int stop;
    int gap;
    int minh;
    int mid;
    int scale;
    int len;
    int r;
    int c;
    pixel_if.valid       = 1'b0;
    pixel_if.pixel_value = '0;
    pixel_if.row_last    = 1'b0;
    result_if.ready      = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    thr_q      = 0;
    start_q    = 0;
    end_q      = 512;
    gap_q      = 1;
    min_hits_q = 1;
    mid_q      = 4096;
    scale_q    = 320;
    clear_row_state();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // directed: score extremes on reset settings, single-item row
    push_item(32767, 1'b1);
    push_item(-32768, 1'b0);
    push_item(0, 1'b0);
    push_item(-1, 1'b1);
    drain();

    // two kept segments, a hit past the window,
    // right center saturating at the frame edge
    configure(256, 1, 15, 2, 2, 128, 16000);
    for (c = 0; c < 16; c++) begin
      case (c)
        2:                      push_item(256, 1'b0);
        3, 5, 8, 10, 11, 13:    push_item(32767, 1'b0);
        4:                      push_item(255, 1'b0);
        15:                     push_item(20000, 1'b1);
        default:                push_item(-32768, 1'b0);
      endcase
    end
    drain();

    // window end below start is raised to one column; zero gap and zero minimum
    configure(-32768, 3, 2, 0, 0, 0, 65535);
    for (c = 0; c < 5; c++) push_item(-32768 + c, c == 4);
    drain();

    // random phases, each with its own settings and idling pattern
    while (rand_items < 950 || rand_rows < 30 || phase_cnt < 7) begin
      lp    = $urandom_range(6, 20);
      thr   = int'($urandom_range(0, 65535)) - 32768;
      start = $urandom_range(0, 3);
      stop  = lp + $urandom_range(0, 2) - 1;
      gap   = $urandom_range(1, 3);
      minh  = $urandom_range(1, 3);
      mid   = lp * 8 + $urandom_range(0, 15) - 8;
      scale = 512 * $urandom_range(60, 700) / lp;
      if (phase_cnt == 1) begin
        thr = 32767; gap = 511; minh = 0; scale = 65535;
      end else if (phase_cnt == 2) begin
        thr = -32768; scale = 1; mid = 0; stop = 0;
      end else if (phase_cnt == 3) begin
        start = 500; stop = 1023; gap = 0; minh = 0; mid = 8191;
      end else if (phase_cnt == 4) begin
        minh = 1023; stop = 512;
      end else if (phase_cnt == 5) begin
        gap = 0; minh = 0;
      end else if (phase_cnt == 6) begin
        start = 511; stop = 1;
      end
      configure(thr, start, stop, gap, minh, mid, scale);
      idle_mode   = phase_cnt % 4;
      phase_items = 0;
      // a row longer than the lane map, hits near its right edge
      if (phase_cnt == 3) queue_row(520, 1'b0, 50);
      while (phase_items < 60) begin
        r = $urandom_range(0, 9);
        if (r == 0)      len = $urandom_range(1, 3);
        else if (r == 1) len = $urandom_range(lp, 2 * lp);
        else             len = lp + $urandom_range(0, 5) - 2;
        queue_row(len, $urandom_range(0, 4) != 0, 50);
      end
      // back up the result path while the sender keeps offering
      if (phase_cnt == 4) hold_requests++;
      drain();
      phase_cnt++;
    end

    mismatches += expected_rows.size();
    $display("%0d pixel items accepted, %0d rows checked over %0d random setting phases",
             accepted_items, rows_checked, phase_cnt);
    $display("%0d rows reported both lanes, %0d mismatches", rows_found, mismatches);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
